FILE: design/barometer_pressure_compensation_top_macros.svh
// Assertion macros shared by the barometer pressure compensation RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BAROMETER_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETER_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// check gated off while reset is high
`define BPC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpc assertion failed");

// check that also holds through reset
`define BPC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("bpc assertion failed");

`endif

FILE: design/bpc_pkg.sv
// Package for the barometer pressure compensation block: widths, codes, types, helpers.
// No dependencies.
package bpc_pkg;

   localparam int DIV_W = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TEMP_DIV0 = 2'd1;
   localparam logic [1:0] STATUS_PRES_DIV0 = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_AC1    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AC2    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_AC3    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AC4    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AC5    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AC6    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_B_PAIR = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_M_PAIR = 4'd7;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] B4_BIAS     = 32'd32768;
   localparam logic [31:0] P_SQ_COEF   = 32'd3038;
   localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343; // -7357
   localparam logic [31:0] P_OFFSET    = 32'd3791;

   localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
   localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
   localparam logic signed [31:0] PRES_MAX = 32'sd262143;

   typedef struct packed {
      logic [31:0] x1;
      logic [15:0] up;
      logic        tz;
      logic        neg;
   } div1_side_type;

   typedef struct packed {
      logic [15:0] temp;
      logic [1:0]  status;
      logic        dbl;
   } div2_side_type;

   // low 32 bits of a 32x32 product
   function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

FILE: design/bpc_req_if.sv
// Request channel: one raw temperature and pressure pair per transaction.
// Depends on nothing.
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [15:0] raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

FILE: design/bpc_rsp_if.sv
// Response channel: compensated temperature, pressure and status per transaction.
// Depends on nothing.
interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] temperature_tenths;
   logic [17:0] pressure_pa;
   logic [1:0]  status;

   modport source (output valid, output temperature_tenths, output pressure_pa,
                   output status, input ready);
   modport sink   (input valid, input temperature_tenths, input pressure_pa,
                   input status, output ready);
endinterface

FILE: design/bpc_udiv.sv
// Pipelined unsigned 32/32 divider, one quotient bit per stage, with sideband.
// Depends on bpc_pkg.
module bpc_udiv #(
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [bpc_pkg::DIV_W-1:0] in_dividend,
   input  logic [bpc_pkg::DIV_W-1:0] in_divisor,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [bpc_pkg::DIV_W-1:0] out_quotient,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int W = bpc_pkg::DIV_W;

   logic [W-1:0]      rem_ff  [1:W];
   logic [W-1:0]      quo_ff  [1:W];
   logic [W-1:0]      dvs_ff  [1:W];
   logic [SIDE_W-1:0] side_ff [1:W];
   logic [W:1]        valid_ff;

   logic [W-1:0]      tap_rem  [0:W];
   logic [W-1:0]      tap_quo  [0:W];
   logic [W-1:0]      tap_dvs  [0:W];
   logic [SIDE_W-1:0] tap_side [0:W];
   logic [W:0]        tap_valid;

   assign tap_rem[0]   = '0;
   assign tap_quo[0]   = in_dividend;
   assign tap_dvs[0]   = in_divisor;
   assign tap_side[0]  = in_side;
   assign tap_valid[0] = in_valid;

   for (genvar k = 1; k <= W; k++) begin : g_stage
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic [W-1:0] rem_in;
      logic [W-1:0] quo_in;

      assign tap_rem[k]   = rem_ff[k];
      assign tap_quo[k]   = quo_ff[k];
      assign tap_dvs[k]   = dvs_ff[k];
      assign tap_side[k]  = side_ff[k];
      assign tap_valid[k] = valid_ff[k];

      always_comb begin
         trial = {tap_rem[k-1], tap_quo[k-1][W-1]};
         diff  = trial - {1'b0, tap_dvs[k-1]};
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {tap_quo[k-1][W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {tap_quo[k-1][W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= tap_valid[k-1];
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            dvs_ff[k]  <= tap_dvs[k-1];
            side_ff[k] <= tap_side[k-1];
         end
      end
   end

   assign out_valid    = tap_valid[W];
   assign out_quotient = tap_quo[W];
   assign out_side     = tap_side[W];

endmodule

FILE: design/barometer_pressure_compensation_top.sv
// Barometric sensor integer compensation (oversampling 0). Each request transaction
// carries a raw temperature and raw pressure word; each response transaction returns
// temperature in 0.1 degC, pressure in Pa (both saturated) and a status code
// (0 ok, 1 temperature divisor zero, 2 pressure divisor zero; fields are 0 when
// status is nonzero). One transaction is accepted every cycle unless stalled; the
// pipe has two 32-stage bit-per-stage dividers plus 14 arithmetic stages and stalls
// as a whole while a finished response is not taken. Calibration registers must be
// written through the csr port only while the block is idle; the block does not
// enforce this. Depends on bpc_pkg, bpc_req_if, bpc_rsp_if, bpc_udiv and the macros header.
`include "barometer_pressure_compensation_top_macros.svh"

module barometer_pressure_compensation_top (
   input  logic                               clock,
   input  logic                               reset,
   bpc_req_if.sink                            req_chan,
   bpc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // calibration registers
   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff, ac5_ff, ac6_ff;
   logic [31:0] b_pair_ff, m_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff    <= '0;
         ac2_ff    <= '0;
         ac3_ff    <= '0;
         ac4_ff    <= '0;
         ac5_ff    <= '0;
         ac6_ff    <= '0;
         b_pair_ff <= '0;
         m_pair_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bpc_pkg::REG_AC1:    ac1_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_AC2:    ac2_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_AC3:    ac3_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_AC4:    ac4_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_AC5:    ac5_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_AC6:    ac6_ff    <= csr_write_data[15:0];
            bpc_pkg::REG_B_PAIR: b_pair_ff <= csr_write_data;
            bpc_pkg::REG_M_PAIR: m_pair_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [31:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
   assign ac1_s = bpc_pkg::sx16(ac1_ff);
   assign ac2_s = bpc_pkg::sx16(ac2_ff);
   assign ac3_s = bpc_pkg::sx16(ac3_ff);
   assign b1_s  = bpc_pkg::sx16(b_pair_ff[31:16]);
   assign b2_s  = bpc_pkg::sx16(b_pair_ff[15:0]);
   assign mc_s  = bpc_pkg::sx16(m_pair_ff[31:16]);
   assign md_s  = bpc_pkg::sx16(m_pair_ff[15:0]);

   // whole pipe moves when the output slot is free or being drained
   logic out_valid_ff;
   logic advance;
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // ---- S1: x1 = ((ut - ac6) * ac5) >> 15
   logic signed [16:0] s1_diff;
   logic signed [33:0] s1_prod;
   logic [31:0]        s1_x1_in;
   logic               s1_valid_ff;
   logic [31:0]        s1_x1_ff;
   logic [15:0]        s1_up_ff;

   assign s1_diff  = $signed({1'b0, req_chan.raw_temperature}) - $signed({1'b0, ac6_ff});
   assign s1_prod  = s1_diff * $signed({1'b0, ac5_ff});
   assign s1_x1_in = $signed(s1_prod[31:0]) >>> 15;

   // ---- S2: denominator and numerator of the temperature division
   logic        s2_valid_ff;
   logic [31:0] s2_den_ff, s2_num_ff, s2_x1_ff;
   logic [15:0] s2_up_ff;

   // ---- S3: magnitudes for the divider
   logic        s3_valid_ff;
   logic [31:0] s3_ma_ff, s3_mb_ff;
   bpc_pkg::div1_side_type s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_x1_ff <= s1_x1_in;
         s1_up_ff <= req_chan.raw_pressure;
         s2_den_ff <= s1_x1_ff + md_s;
         s2_num_ff <= {mc_s[20:0], 11'b0};
         s2_x1_ff  <= s1_x1_ff;
         s2_up_ff  <= s1_up_ff;
         s3_ma_ff  <= s2_num_ff[31] ? (32'd0 - s2_num_ff) : s2_num_ff;
         s3_mb_ff  <= s2_den_ff[31] ? (32'd0 - s2_den_ff) : s2_den_ff;
         s3_side_ff.x1  <= s2_x1_ff;
         s3_side_ff.up  <= s2_up_ff;
         s3_side_ff.tz  <= (s2_den_ff == 32'd0);
         s3_side_ff.neg <= s2_num_ff[31] ^ s2_den_ff[31];
      end
   end

   // ---- temperature divider
   logic                   d1_valid;
   logic [31:0]            d1_q;
   logic [$bits(bpc_pkg::div1_side_type)-1:0] d1_side_raw;
   bpc_pkg::div1_side_type d1_side;

   bpc_udiv #(.SIDE_W($bits(bpc_pkg::div1_side_type))) u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_ma_ff),
      .in_divisor   (s3_mb_ff),
      .in_side      (s3_side_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_q),
      .out_side     (d1_side_raw)
   );
   assign d1_side = d1_side_raw;

   // ---- S4: b5
   logic        s4_valid_ff, s4_tz_ff;
   logic [31:0] s4_b5_ff;
   logic [15:0] s4_up_ff;
   logic [31:0] s4_x2;
   assign s4_x2 = d1_side.neg ? (32'd0 - d1_q) : d1_q;

   // ---- S5: b6 and saturated temperature
   logic        s5_valid_ff, s5_tz_ff;
   logic [31:0] s5_b6_ff;
   logic [15:0] s5_up_ff, s5_t_ff;
   logic signed [31:0] s5_t32;
   logic [15:0]        s5_t_in;

   always_comb begin
      s5_t32 = $signed(s4_b5_ff + 32'd8) >>> 4;
      if (s5_t32 > bpc_pkg::TEMP_MAX) begin
         s5_t_in = bpc_pkg::TEMP_MAX[15:0];
      end else if (s5_t32 < bpc_pkg::TEMP_MIN) begin
         s5_t_in = bpc_pkg::TEMP_MIN[15:0];
      end else begin
         s5_t_in = s5_t32[15:0];
      end
   end

   // ---- S6: b6 products
   logic        s6_valid_ff, s6_tz_ff;
   logic [31:0] s6_b6sq_ff, s6_ac2b6_ff, s6_ac3b6_ff;
   logic [15:0] s6_up_ff, s6_t_ff;

   // ---- S7: sq-based products
   logic        s7_valid_ff, s7_tz_ff;
   logic [31:0] s7_sq, s7_b2sq_ff, s7_b1sq_ff, s7_ac2b6_ff, s7_ac3b6_ff;
   logic [15:0] s7_up_ff, s7_t_ff;
   assign s7_sq = $signed(s6_b6sq_ff) >>> 12;

   // ---- S8: b3 and x3
   logic        s8_valid_ff, s8_tz_ff;
   logic [31:0] s8_b3_ff, s8_x3_ff;
   logic [15:0] s8_up_ff, s8_t_ff;
   logic [31:0] s8_x3a, s8_v, s8_b3_in, s8_x3_sum, s8_x3_in, s8_ac3_sh, s8_b1_sh;

   always_comb begin
      s8_x3a = ($signed(s7_b2sq_ff) >>> 11) + ($signed(s7_ac2b6_ff) >>> 11);
      s8_v   = {ac1_s[29:0], 2'b00} + s8_x3a + 32'd2;
      // divide by four, truncating toward zero
      if (s8_v[31]) begin
         s8_b3_in = $signed(s8_v + 32'd3) >>> 2;
      end else begin
         s8_b3_in = $signed(s8_v) >>> 2;
      end
      // shifts kept apart so they stay arithmetic
      s8_ac3_sh = $signed(s7_ac3b6_ff) >>> 13;
      s8_b1_sh  = $signed(s7_b1sq_ff) >>> 16;
      s8_x3_sum = s8_ac3_sh + s8_b1_sh + 32'd2;
      s8_x3_in  = $signed(s8_x3_sum) >>> 2;
   end

   // ---- S9: b4 product and up - b3
   logic        s9_valid_ff, s9_tz_ff;
   logic [31:0] s9_b4p_ff, s9_diff_ff;
   logic [15:0] s9_t_ff;

   // ---- S10: b4, b7
   logic        s10_valid_ff;
   logic [31:0] s10_b4_ff, s10_b7_ff;
   logic [15:0] s10_t_ff;
   logic [1:0]  s10_status_ff;
   logic [31:0] s10_b4_in;
   assign s10_b4_in = {15'd0, s9_b4p_ff[31:15]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= d1_valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
      if (advance) begin
         s4_b5_ff <= d1_side.x1 + s4_x2;
         s4_up_ff <= d1_side.up;
         s4_tz_ff <= d1_side.tz;

         s5_b6_ff <= s4_b5_ff - bpc_pkg::B6_OFFSET;
         s5_t_ff  <= s5_t_in;
         s5_up_ff <= s4_up_ff;
         s5_tz_ff <= s4_tz_ff;

         s6_b6sq_ff  <= bpc_pkg::mul_lo(s5_b6_ff, s5_b6_ff);
         s6_ac2b6_ff <= bpc_pkg::mul_lo(ac2_s, s5_b6_ff);
         s6_ac3b6_ff <= bpc_pkg::mul_lo(ac3_s, s5_b6_ff);
         s6_up_ff    <= s5_up_ff;
         s6_t_ff     <= s5_t_ff;
         s6_tz_ff    <= s5_tz_ff;

         s7_b2sq_ff  <= bpc_pkg::mul_lo(b2_s, s7_sq);
         s7_b1sq_ff  <= bpc_pkg::mul_lo(b1_s, s7_sq);
         s7_ac2b6_ff <= s6_ac2b6_ff;
         s7_ac3b6_ff <= s6_ac3b6_ff;
         s7_up_ff    <= s6_up_ff;
         s7_t_ff     <= s6_t_ff;
         s7_tz_ff    <= s6_tz_ff;

         s8_b3_ff <= s8_b3_in;
         s8_x3_ff <= s8_x3_in;
         s8_up_ff <= s7_up_ff;
         s8_t_ff  <= s7_t_ff;
         s8_tz_ff <= s7_tz_ff;

         s9_b4p_ff  <= bpc_pkg::mul_lo({16'd0, ac4_ff}, s8_x3_ff + bpc_pkg::B4_BIAS);
         s9_diff_ff <= {16'd0, s8_up_ff} - s8_b3_ff;
         s9_t_ff    <= s8_t_ff;
         s9_tz_ff   <= s8_tz_ff;

         s10_b4_ff <= s10_b4_in;
         s10_b7_ff <= bpc_pkg::mul_lo(s9_diff_ff, bpc_pkg::B7_SCALE);
         s10_t_ff  <= s9_t_ff;
         if (s9_tz_ff) begin
            s10_status_ff <= bpc_pkg::STATUS_TEMP_DIV0;
         end else if (s10_b4_in == 32'd0) begin
            s10_status_ff <= bpc_pkg::STATUS_PRES_DIV0;
         end else begin
            s10_status_ff <= bpc_pkg::STATUS_OK;
         end
      end
   end

   // ---- pressure divider: b7 < 2^31 divides b7*2, else divides b7 and doubles
   logic [31:0]            d2_dividend;
   bpc_pkg::div2_side_type d2_side_in;
   logic                   d2_valid;
   logic [31:0]            d2_q;
   logic [$bits(bpc_pkg::div2_side_type)-1:0] d2_side_raw;
   bpc_pkg::div2_side_type d2_side;

   assign d2_dividend       = s10_b7_ff[31] ? s10_b7_ff : {s10_b7_ff[30:0], 1'b0};
   assign d2_side_in.temp   = s10_t_ff;
   assign d2_side_in.status = s10_status_ff;
   assign d2_side_in.dbl    = s10_b7_ff[31];

   bpc_udiv #(.SIDE_W($bits(bpc_pkg::div2_side_type))) u_div_pres (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (s10_valid_ff),
      .in_dividend  (d2_dividend),
      .in_divisor   (s10_b4_ff),
      .in_side      (d2_side_in),
      .out_valid    (d2_valid),
      .out_quotient (d2_q),
      .out_side     (d2_side_raw)
   );
   assign d2_side = d2_side_raw;

   // ---- S12: p
   logic        s12_valid_ff;
   logic [31:0] s12_p_ff;
   logic [15:0] s12_t_ff;
   logic [1:0]  s12_status_ff;

   // ---- S13: (p>>8)^2 and -7357*p
   logic        s13_valid_ff;
   logic [31:0] s13_p8, s13_sqp_ff, s13_m2_ff, s13_p_ff;
   logic [15:0] s13_t_ff;
   logic [1:0]  s13_status_ff;
   assign s13_p8 = $signed(s12_p_ff) >>> 8;

   // ---- S14: *3038
   logic        s14_valid_ff;
   logic [31:0] s14_x1_ff, s14_x2_ff, s14_p_ff;
   logic [15:0] s14_t_ff;
   logic [1:0]  s14_status_ff;

   // ---- S15: final pressure, saturation, output register
   logic [31:0]        s15_sum, s15_x1_sh, s15_sum_sh;
   logic signed [31:0] s15_p;
   logic [17:0]        s15_p_sat;
   logic [15:0]        out_temp_ff;
   logic [17:0]        out_pres_ff;
   logic [1:0]         out_status_ff;

   always_comb begin
      s15_x1_sh  = $signed(s14_x1_ff) >>> 16;
      s15_sum    = s15_x1_sh + s14_x2_ff + bpc_pkg::P_OFFSET;
      s15_sum_sh = $signed(s15_sum) >>> 4;
      s15_p      = $signed(s14_p_ff + s15_sum_sh);
      if (s15_p < 0) begin
         s15_p_sat = '0;
      end else if (s15_p > bpc_pkg::PRES_MAX) begin
         s15_p_sat = bpc_pkg::PRES_MAX[17:0];
      end else begin
         s15_p_sat = s15_p[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
         s13_valid_ff <= 1'b0;
         s14_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s12_valid_ff <= d2_valid;
         s13_valid_ff <= s12_valid_ff;
         s14_valid_ff <= s13_valid_ff;
         out_valid_ff <= s14_valid_ff;
      end
      if (advance) begin
         s12_p_ff      <= d2_side.dbl ? {d2_q[30:0], 1'b0} : d2_q;
         s12_t_ff      <= d2_side.temp;
         s12_status_ff <= d2_side.status;

         s13_sqp_ff    <= bpc_pkg::mul_lo(s13_p8, s13_p8);
         s13_m2_ff     <= bpc_pkg::mul_lo(bpc_pkg::P_LIN_COEF, s12_p_ff);
         s13_p_ff      <= s12_p_ff;
         s13_t_ff      <= s12_t_ff;
         s13_status_ff <= s12_status_ff;

         s14_x1_ff     <= bpc_pkg::mul_lo(s13_sqp_ff, bpc_pkg::P_SQ_COEF);
         s14_x2_ff     <= $signed(s13_m2_ff) >>> 16;
         s14_p_ff      <= s13_p_ff;
         s14_t_ff      <= s13_t_ff;
         s14_status_ff <= s13_status_ff;

         out_status_ff <= s14_status_ff;
         if (s14_status_ff == bpc_pkg::STATUS_OK) begin
            out_temp_ff <= s14_t_ff;
            out_pres_ff <= s15_p_sat;
         end else begin
            out_temp_ff <= '0;
            out_pres_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.temperature_tenths = out_temp_ff;
   assign rsp_chan.pressure_pa        = out_pres_ff;
   assign rsp_chan.status             = out_status_ff;

   // a flagged transaction carries zero fields
   `BPC_ASSERT(a_fault_zero, clock, reset, (out_valid_ff && out_status_ff != bpc_pkg::STATUS_OK) |-> (out_temp_ff == 16'd0 && out_pres_ff == 18'd0))
   // a stall freezes the pipe front
   `BPC_ASSERT(a_stall_freeze, clock, reset, (!advance) |=> ($stable(s1_valid_ff) && $stable(s1_x1_ff)))
   // nothing is offered right after reset
   `BPC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !out_valid_ff)

endmodule
